// ===== rtl/sba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sba_pkg: shared types and constants of the sensor block averager
// Field widths, word layouts and control structs used by every module.
// ----------------------------------------------------------------------------
package sba_pkg;

   localparam int BOARD_W = 15;
   localparam int PROBE_W = 15;
   localparam int HUMID_W = 14;
   localparam int PRESS_W = 17;
   localparam int SOIL_W  = 14;
   localparam int STAMP_W = 32;
   localparam int FLAGS_W = 8;
   localparam int COUNT_W = 9;

   localparam int RESET_INTERVAL = 20;

   localparam int REQ_DATA_W = 120;
   localparam int RSP_DATA_W = 160;

   // input word, first member in the highest bits so board_temp lands at bit 0
   typedef struct packed {
      logic [FLAGS_W-1:0] sensor_flags;
      logic [STAMP_W-1:0] time_ms;
      logic [SOIL_W-1:0]  soil_level;
      logic [PRESS_W-1:0] pressure;
      logic [HUMID_W-1:0] humidity;
      logic [PROBE_W-1:0] probe_temp;
      logic [BOARD_W-1:0] board_temp;
   } reading_type;

   // result word, mean_board_temp at bit 0
   typedef struct packed {
      logic [FLAGS_W-1:0] last_flags;
      logic [COUNT_W-1:0] readings_used;
      logic [STAMP_W-1:0] last_ms;
      logic [STAMP_W-1:0] first_ms;
      logic [SOIL_W-1:0]  mean_soil;
      logic [PRESS_W-1:0] mean_pressure;
      logic [HUMID_W-1:0] mean_humidity;
      logic [PROBE_W-1:0] mean_probe_temp;
      logic [BOARD_W-1:0] mean_board_temp;
   } record_type;

   typedef struct packed {
      logic add;
      logic clear;
   } acc_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== rtl/sba_accum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sba_accum: running sums and block bookkeeping
// Holds the five channel sums, the fill count, the first and last stamps and
// the status byte of the last reading.
// ----------------------------------------------------------------------------
module sba_accum import sba_pkg::*; #(
   parameter int EXT_W = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  acc_cmd_type                       cmd,
   input  reading_type                       reading,
   output logic signed [BOARD_W+EXT_W-1:0]   board_sum,
   output logic signed [PROBE_W+EXT_W-1:0]   probe_sum,
   output logic        [HUMID_W+EXT_W-1:0]   humid_sum,
   output logic        [PRESS_W+EXT_W-1:0]   press_sum,
   output logic        [SOIL_W+EXT_W-1:0]    soil_sum,
   output logic        [COUNT_W-1:0]         fill_count,
   output logic        [STAMP_W-1:0]         first_stamp,
   output logic        [STAMP_W-1:0]         last_stamp,
   output logic        [FLAGS_W-1:0]         status_hold
);

   localparam int BSUM_W = BOARD_W + EXT_W;
   localparam int PSUM_W = PROBE_W + EXT_W;
   localparam int HSUM_W = HUMID_W + EXT_W;
   localparam int RSUM_W = PRESS_W + EXT_W;
   localparam int SSUM_W = SOIL_W + EXT_W;

   logic signed [BSUM_W-1:0] board_sum_ff;
   logic signed [PSUM_W-1:0] probe_sum_ff;
   logic        [HSUM_W-1:0] humid_sum_ff;
   logic        [RSUM_W-1:0] press_sum_ff;
   logic        [SSUM_W-1:0] soil_sum_ff;
   logic        [COUNT_W-1:0] fill_ff;
   logic        [STAMP_W-1:0] first_ff;
   logic        [STAMP_W-1:0] last_ff;
   logic        [FLAGS_W-1:0] flags_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         board_sum_ff <= '0;
         probe_sum_ff <= '0;
         humid_sum_ff <= '0;
         press_sum_ff <= '0;
         soil_sum_ff  <= '0;
         fill_ff      <= '0;
         first_ff     <= '0;
         last_ff      <= '0;
         flags_ff     <= '0;
      end else if (cmd.add) begin
         board_sum_ff <= board_sum_ff + BSUM_W'($signed(reading.board_temp));
         probe_sum_ff <= probe_sum_ff + PSUM_W'($signed(reading.probe_temp));
         humid_sum_ff <= humid_sum_ff + HSUM_W'(reading.humidity);
         press_sum_ff <= press_sum_ff + RSUM_W'(reading.pressure);
         soil_sum_ff  <= soil_sum_ff + SSUM_W'(reading.soil_level);
         fill_ff      <= fill_ff + 1'b1;
         if (fill_ff == '0) begin
            first_ff <= reading.time_ms;
         end
         last_ff  <= reading.time_ms;
         flags_ff <= reading.sensor_flags;
      end
   end

   assign board_sum   = board_sum_ff;
   assign probe_sum   = probe_sum_ff;
   assign humid_sum   = humid_sum_ff;
   assign press_sum   = press_sum_ff;
   assign soil_sum    = soil_sum_ff;
   assign fill_count  = fill_ff;
   assign first_stamp = first_ff;
   assign last_stamp  = last_ff;
   assign status_hold = flags_ff;

endmodule

// ===== rtl/sba_serial_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sba_serial_div: bit-serial signed divider by the fill count
// Restoring division, one quotient bit per cycle, truncation toward zero.
// ----------------------------------------------------------------------------
module sba_serial_div import sba_pkg::*; #(
   parameter int DW = 25
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DW:0]        operand,
   input  logic [COUNT_W-1:0] divisor,
   output div_status_type     status,
   output logic [DW-1:0]      quotient
);

   localparam int STEP_W = $clog2(DW);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DW - 1);

   logic [STEP_W-1:0]  step_ff;
   logic               busy_ff;
   logic               done_ff;
   logic               neg_ff;
   logic [COUNT_W-1:0] dvs_ff;
   logic [COUNT_W-1:0] rem_ff;
   logic [COUNT_W-1:0] rem_in;
   logic [DW-1:0]      quo_ff;
   logic [DW:0]        mag_full;
   logic [COUNT_W:0]   trial;
   logic [COUNT_W:0]   diff;
   logic               fits;

   assign mag_full = operand[DW] ? (~operand + 1'b1) : operand;
   assign trial    = {rem_ff, quo_ff[DW-1]};
   assign diff     = trial - {1'b0, dvs_ff};
   assign fits     = (trial >= {1'b0, dvs_ff});
   assign rem_in   = fits ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
            neg_ff  <= operand[DW];
            dvs_ff  <= divisor;
            rem_ff  <= '0;
            quo_ff  <= mag_full[DW-1:0];
         end else if (busy_ff) begin
            // shift the next dividend bit into the remainder, the quotient bit in
            rem_ff <= rem_in;
            quo_ff <= {quo_ff[DW-2:0], fits};
            if (step_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               step_ff <= step_ff + 1'b1;
            end
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("divider did not start");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still busy");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (step_ff <= LAST_STEP))
      else $error("divider step past quotient width");

endmodule

// ===== rtl/sensor_block_averager.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_block_averager: block-average decimator for five-channel readings
// Sums readings, then publishes one averaged record per publish interval.
// ----------------------------------------------------------------------------
// Each accepted word is one reading; it is added to the running sums in the
// cycle it is taken, and a reading that does not close a block leaves the
// block ready for the next word. When the fill count reaches publish_interval
// (or already stands at or above it after the interval was lowered, in which
// case the new reading is dropped) the block stops taking words and runs the
// five channel means through one shared bit-serial divider of DIV_W bits,
// where DIV_W = 17 + clog2 of the max interval held between 20 and 511: 25
// at the default MAX_INTERVAL of 256. The finished record sits in an output
// register; the next block is accepted while it waits, and only a second
// record that finds the register still full waits on rsp_tready.
// publish_interval is clamped on write: 0 reads as 1 and values above
// MAX_INTERVAL read as MAX_INTERVAL; it resets to 20.
// ----------------------------------------------------------------------------
module sensor_block_averager import sba_pkg::*; #(
   parameter int MAX_INTERVAL = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   // reading words, low bit up: board_temp[15], probe_temp[15], humidity[14],
   // pressure[17], soil_level[14], time_ms[32], sensor_flags[8], zero pad
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // record words, low bit up: mean_board_temp[15], mean_probe_temp[15],
   // mean_humidity[14], mean_pressure[17], mean_soil[14], first_ms[32],
   // last_ms[32], readings_used[9], last_flags[8], zero pad
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // publish_interval write port
   input  logic                  csr_we,
   input  logic [COUNT_W-1:0]    csr_wdata
);

   // a 9-bit register cannot hold more than 511
   localparam int EFF_MAX = (MAX_INTERVAL < 511) ? MAX_INTERVAL : 511;
   // the reset interval may exceed a small maximum until the first write
   localparam int SPAN  = (EFF_MAX > RESET_INTERVAL) ? EFF_MAX : RESET_INTERVAL;
   localparam int EXT_W = $clog2(SPAN);
   localparam int DIV_W = PRESS_W + EXT_W;
   localparam logic [COUNT_W-1:0] MAX_CODE = COUNT_W'(EFF_MAX);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_WAIT,
      ST_PUBLISH
   } state_type;

   typedef enum logic [2:0] {
      CH_BOARD,
      CH_PROBE,
      CH_HUMID,
      CH_PRESS,
      CH_SOIL
   } chan_type;

   state_type          state_ff;
   chan_type           chan_ff;
   logic [COUNT_W-1:0] interval_ff;
   logic [COUNT_W-1:0] interval_in;
   logic               rsp_valid_ff;
   record_type         record_ff;

   logic [BOARD_W-1:0] mean_board_ff;
   logic [PROBE_W-1:0] mean_probe_ff;
   logic [HUMID_W-1:0] mean_humid_ff;
   logic [PRESS_W-1:0] mean_press_ff;
   logic [SOIL_W-1:0]  mean_soil_ff;

   reading_type        reading;
   acc_cmd_type        acc_cmd;
   div_status_type     div_status;

   logic signed [BOARD_W+EXT_W-1:0] board_sum;
   logic signed [PROBE_W+EXT_W-1:0] probe_sum;
   logic        [HUMID_W+EXT_W-1:0] humid_sum;
   logic        [PRESS_W+EXT_W-1:0] press_sum;
   logic        [SOIL_W+EXT_W-1:0]  soil_sum;
   logic        [COUNT_W-1:0]       fill_count;
   logic        [STAMP_W-1:0]       first_stamp;
   logic        [STAMP_W-1:0]       last_stamp;
   logic        [FLAGS_W-1:0]       status_hold;

   logic               req_fire;
   logic               rsp_fire;
   logic               room;
   logic [COUNT_W-1:0] fill_next;
   logic               emit;
   logic               publish_load;
   logic               div_start;
   logic [DIV_W:0]     div_operand;
   logic [DIV_W-1:0]   div_quotient;

   // ---------------------------------------------------------------------
   // configuration: clamp on write
   // ---------------------------------------------------------------------
   always_comb begin
      priority if (csr_wdata == '0) begin
         interval_in = COUNT_W'(1);
      end else if (csr_wdata > MAX_CODE) begin
         interval_in = MAX_CODE;
      end else begin
         interval_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= COUNT_W'(RESET_INTERVAL);
      end else if (csr_we) begin
         interval_ff <= interval_in;
      end
   end

   // ---------------------------------------------------------------------
   // intake: add the reading while the block has room, else drop it
   // ---------------------------------------------------------------------
   assign reading    = reading_type'(req_tdata[$bits(reading_type)-1:0]);
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_valid_ff && rsp_tready;

   assign room      = (fill_count < interval_ff);
   assign fill_next = fill_count + 1'b1;
   // close the block when it is full now or this reading fills it
   assign emit      = !room || (fill_next >= interval_ff);

   assign publish_load  = (state_ff == ST_PUBLISH) && (!rsp_valid_ff || rsp_tready);
   assign acc_cmd.add   = req_fire && room;
   assign acc_cmd.clear = publish_load;

   sba_accum #(
      .EXT_W (EXT_W)
   ) u_accum (
      .clock       (clock),
      .reset       (reset),
      .cmd         (acc_cmd),
      .reading     (reading),
      .board_sum   (board_sum),
      .probe_sum   (probe_sum),
      .humid_sum   (humid_sum),
      .press_sum   (press_sum),
      .soil_sum    (soil_sum),
      .fill_count  (fill_count),
      .first_stamp (first_stamp),
      .last_stamp  (last_stamp),
      .status_hold (status_hold)
   );

   // ---------------------------------------------------------------------
   // divider feed: a channel at a time, sign- or zero-extended to one width
   // ---------------------------------------------------------------------
   always_comb begin
      unique case (chan_ff)
         CH_BOARD: div_operand = (DIV_W + 1)'(board_sum);
         CH_PROBE: div_operand = (DIV_W + 1)'(probe_sum);
         CH_HUMID: div_operand = (DIV_W + 1)'(humid_sum);
         CH_PRESS: div_operand = (DIV_W + 1)'(press_sum);
         CH_SOIL:  div_operand = (DIV_W + 1)'(soil_sum);
         default:  div_operand = '0;
      endcase
   end

   assign div_start = (state_ff == ST_LAUNCH);

   sba_serial_div #(
      .DW (DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .operand  (div_operand),
      .divisor  (fill_count),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // ---------------------------------------------------------------------
   // sequencer, mean staging and output register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chan_ff      <= CH_BOARD;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire && emit) begin
                  chan_ff  <= CH_BOARD;
                  state_ff <= ST_LAUNCH;
               end
            end
            ST_LAUNCH: begin
               state_ff <= ST_WAIT;
            end
            ST_WAIT: begin
               if (div_status.done) begin
                  unique case (chan_ff)
                     CH_BOARD: mean_board_ff <= div_quotient[BOARD_W-1:0];
                     CH_PROBE: mean_probe_ff <= div_quotient[PROBE_W-1:0];
                     CH_HUMID: mean_humid_ff <= div_quotient[HUMID_W-1:0];
                     CH_PRESS: mean_press_ff <= div_quotient[PRESS_W-1:0];
                     CH_SOIL:  mean_soil_ff  <= div_quotient[SOIL_W-1:0];
                     default: ;
                  endcase
                  if (chan_ff == CH_SOIL) begin
                     // all five means staged; the waiting record stays intact
                     state_ff <= ST_PUBLISH;
                  end else begin
                     chan_ff  <= chan_type'(chan_ff + 1'b1);
                     state_ff <= ST_LAUNCH;
                  end
               end
            end
            ST_PUBLISH: begin
               if (publish_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase

         // hold the word until taken; load a new record into a free register
         if (publish_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      if (publish_load) begin
         record_ff.mean_board_temp <= mean_board_ff;
         record_ff.mean_probe_temp <= mean_probe_ff;
         record_ff.mean_humidity   <= mean_humid_ff;
         record_ff.mean_pressure   <= mean_press_ff;
         record_ff.mean_soil       <= mean_soil_ff;
         record_ff.first_ms        <= first_stamp;
         record_ff.last_ms         <= last_stamp;
         record_ff.readings_used   <= fill_count;
         record_ff.last_flags      <= status_hold;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(record_ff);

   a_close_launch: assert property (@(posedge clock) disable iff (reset)
      (req_fire && emit) |=> (state_ff == ST_LAUNCH))
      else $error("closing reading did not start the divider");
   a_done_waiting: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_WAIT))
      else $error("divider result arrived outside the wait state");
   a_publish_clear: assert property (@(posedge clock) disable iff (reset)
      publish_load |=> (fill_count == '0) && rsp_valid_ff)
      else $error("publish did not clear the block or raise the record");

endmodule

// ===== verif/sensor_block_averager_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_block_averager_tb: self-checking bench for the block averager
// Streams sensor readings into the averager under several publish intervals
// and idle patterns. A software mirror of the accumulator predicts each
// averaged record, and a free-running receiver compares every record word
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module sensor_block_averager_tb;
   import sba_pkg::*;

   localparam int     MAX_INTERVAL  = 256;
   localparam int     CLOCK_HALF    = 2;
   localparam int     RESET_CYCLES  = 9;
   // time a closing reading spends in the shared divider
   localparam int     DIVIDE_CYCLES = 137;
   localparam int     SETTLE_CYCLES = 2 * DIVIDE_CYCLES;
   localparam int     RANDOM_PHASE  = 55;
   localparam longint CYCLE_LIMIT   = 1_000_000;

   // stimulus kinds for the directed part
   typedef enum int {
      PAT_DOC_MIN,
      PAT_DOC_MAX,
      PAT_MOST_NEG,
      PAT_MOST_POS,
      PAT_MINUS_ONE,
      PAT_RANDOM
   } pattern_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic [COUNT_W-1:0]    csr_wdata;

   // idle percentages, read each cycle by the receiver, per word by the sender
   int     send_idle_pct  = 0;
   int     rsp_stall_pct  = 0;
   int     mismatch_count = 0;
   longint cycle_count    = 0;

   // mirror of the accumulator and its interval register
   int unsigned        interval_now   = RESET_INTERVAL;
   int unsigned        held_count     = 0;
   longint             acc_board      = 0;
   longint             acc_probe      = 0;
   longint             acc_humid      = 0;
   longint             acc_press      = 0;
   longint             acc_soil       = 0;
   logic [STAMP_W-1:0] block_first_ms = '0;
   logic [STAMP_W-1:0] block_last_ms  = '0;
   logic [FLAGS_W-1:0] block_flags    = '0;
   record_type         expected_records[$];

   sensor_block_averager #(
      .MAX_INTERVAL(MAX_INTERVAL)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_HALF) clock = ~clock;
   end

   // Hard stop: a stuck handshake or a lost record ends up here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Fold one accepted reading into the mirror; queue the record it closes.
   // A reading that arrives while the held count already meets a lowered
   // interval is dropped, and the held readings are published on their own.
   function automatic void accumulate_reading(reading_type r);
      record_type rec;
      longint     cnt;
      if (held_count < interval_now) begin
         if (held_count == 0)
            block_first_ms = r.time_ms;
         acc_board += longint'($signed(r.board_temp));
         acc_probe += longint'($signed(r.probe_temp));
         acc_humid += longint'(r.humidity);
         acc_press += longint'(r.pressure);
         acc_soil  += longint'(r.soil_level);
         block_last_ms = r.time_ms;
         block_flags   = r.sensor_flags;
         held_count++;
      end
      if (held_count < interval_now || held_count == 0)
         return;
      cnt = longint'(held_count);
      // signed division truncates toward zero, as the averager does
      rec.mean_board_temp = BOARD_W'(acc_board / cnt);
      rec.mean_probe_temp = PROBE_W'(acc_probe / cnt);
      rec.mean_humidity   = HUMID_W'(acc_humid / cnt);
      rec.mean_pressure   = PRESS_W'(acc_press / cnt);
      rec.mean_soil       = SOIL_W'(acc_soil / cnt);
      rec.first_ms        = block_first_ms;
      rec.last_ms         = block_last_ms;
      rec.readings_used   = COUNT_W'(held_count);
      rec.last_flags      = block_flags;
      expected_records.push_back(rec);
      // the block clears itself after publishing
      held_count     = 0;
      acc_board      = 0;
      acc_probe      = 0;
      acc_humid      = 0;
      acc_press      = 0;
      acc_soil       = 0;
      block_first_ms = '0;
      block_last_ms  = '0;
      block_flags    = '0;
   endfunction

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------

   function automatic void check_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic void check_record(record_type got);
      record_type want;
      if (expected_records.size() == 0) begin
         $error("record word arrived with no record pending");
         mismatch_count++;
         return;
      end
      want = expected_records.pop_front();
      check_field("mean_board_temp", $signed(want.mean_board_temp),
                  $signed(got.mean_board_temp));
      check_field("mean_probe_temp", $signed(want.mean_probe_temp),
                  $signed(got.mean_probe_temp));
      check_field("mean_humidity", want.mean_humidity, got.mean_humidity);
      check_field("mean_pressure", want.mean_pressure, got.mean_pressure);
      check_field("mean_soil", want.mean_soil, got.mean_soil);
      check_field("first_ms", want.first_ms, got.first_ms);
      check_field("last_ms", want.last_ms, got.last_ms);
      check_field("readings_used", want.readings_used, got.readings_used);
      check_field("last_flags", want.last_flags, got.last_flags);
   endfunction

   // Receiver: sample the record channel at each edge, take the word if the
   // handshake completed, then pick the next cycle's ready at random.
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            check_record(record_type'(rsp_tdata[$bits(record_type)-1:0]));
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Mostly readings inside the sensors' ranges; one in four is a raw bit
   // pattern so every bit of every field toggles.
   function automatic reading_type random_reading();
      reading_type r;
      if ($urandom_range(3) == 0) begin
         r.board_temp = BOARD_W'($urandom());
         r.probe_temp = PROBE_W'($urandom());
         r.humidity   = HUMID_W'($urandom());
         r.pressure   = PRESS_W'($urandom());
         r.soil_level = SOIL_W'($urandom());
      end else begin
         r.board_temp = BOARD_W'(int'($urandom_range(16500)) - 4000);
         r.probe_temp = PROBE_W'(int'($urandom_range(18000)) - 5500);
         r.humidity   = HUMID_W'($urandom_range(10000));
         r.pressure   = PRESS_W'($urandom_range(131071));
         r.soil_level = SOIL_W'($urandom_range(10000));
      end
      r.time_ms      = $urandom();
      r.sensor_flags = FLAGS_W'($urandom());
      return r;
   endfunction

   function automatic reading_type pattern_reading(pattern_type kind);
      reading_type r;
      r = random_reading();
      case (kind)
         PAT_DOC_MIN: begin
            r = '0;
            r.board_temp = BOARD_W'(-4000);
            r.probe_temp = PROBE_W'(-5500);
         end
         PAT_DOC_MAX: begin
            r.board_temp    = BOARD_W'(12500);
            r.probe_temp    = PROBE_W'(12500);
            r.humidity      = HUMID_W'(10000);
            r.pressure      = '1;
            r.soil_level    = SOIL_W'(10000);
            r.time_ms       = '1;
            r.sensor_flags  = '1;
         end
         PAT_MOST_NEG: begin
            r.board_temp    = {1'b1, {(BOARD_W-1){1'b0}}};
            r.probe_temp    = {1'b1, {(PROBE_W-1){1'b0}}};
            r.humidity      = '1;
            r.pressure      = '1;
            r.soil_level    = '1;
            r.sensor_flags  = 8'h55;
         end
         PAT_MOST_POS: begin
            r               = '0;
            r.board_temp    = {1'b0, {(BOARD_W-1){1'b1}}};
            r.probe_temp    = {1'b0, {(PROBE_W-1){1'b1}}};
            r.time_ms       = 32'h8000_0000;
            r.sensor_flags  = 8'hAA;
         end
         PAT_MINUS_ONE: begin
            r.board_temp    = '1;
            r.probe_temp    = '1;
            r.humidity      = HUMID_W'(1);
            r.pressure      = PRESS_W'(1);
            r.soil_level    = SOIL_W'(1);
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic set_idling(input int send_pct, input int stall_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
   endtask

   // Offer one reading word, holding it until the averager takes it, and
   // predict at the accepting edge. Valid stays high between back-to-back
   // words and drops only while the sender idles.
   task automatic send_reading(input reading_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(r);
      do @(posedge clock); while (!req_tready);
      accumulate_reading(r);
   endtask

   // Drop valid, wait for every pending record, then give the divider time
   // to finish any block still in flight.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_records.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write publish_interval for one cycle and mirror the clamp.
   task automatic write_interval(input logic [COUNT_W-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (value == 0)
         interval_now = 1;
      else if (value > MAX_INTERVAL)
         interval_now = MAX_INTERVAL;
      else
         interval_now = value;
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // One full block at the reset interval, led by the field extremes.
   task automatic test_default_interval();
      int n;
      set_idling(0, 0);
      for (n = 0; n < RESET_INTERVAL; n++) begin
         if (n < int'(PAT_RANDOM))
            send_reading(pattern_reading(pattern_type'(n)));
         else
            send_reading(random_reading());
      end
      wait_idle();
   endtask

   // Zero clamps to one reading per record; the top code clamps to the max.
   task automatic test_interval_clamp();
      write_interval('0);
      send_reading(pattern_reading(PAT_MOST_NEG));
      wait_idle();
      write_interval('1);
      send_reading(pattern_reading(PAT_DOC_MAX));
      send_reading(pattern_reading(PAT_MINUS_ONE));
      send_reading(pattern_reading(PAT_MOST_POS));
      wait_idle();
   endtask

   // Lower the interval under the held count: the next reading is dropped
   // and the three held readings publish on their own.
   task automatic test_interval_lowered();
      write_interval(COUNT_W'(2));
      send_reading(pattern_reading(PAT_DOC_MIN));
      wait_idle();
   endtask

   // Random phases across every idle pattern. Leftover fill carries across
   // interval writes, so lowered intervals recur at random too.
   task automatic test_random_blocks();
      int mode;
      int phase;
      int n;
      for (mode = 0; mode < 4; mode++) begin
         case (mode)
            0:       set_idling(0, 0);
            1:       set_idling(82, 0);
            2:       set_idling(0, 82);
            default: set_idling(16, 16);
         endcase
         for (phase = 0; phase < 3; phase++) begin
            case (phase)
               0:       write_interval(COUNT_W'($urandom_range(1, 4)));
               1:       write_interval(COUNT_W'($urandom_range(5, 24)));
               default: write_interval(COUNT_W'($urandom_range((1 << COUNT_W) - 1)));
            endcase
            for (n = 0; n < RANDOM_PHASE; n++)
               send_reading(random_reading());
            wait_idle();
         end
      end
      // one long block at the top of the interval range
      write_interval(COUNT_W'($urandom_range(MAX_INTERVAL, (1 << COUNT_W) - 1)));
      for (n = 0; n < MAX_INTERVAL + 4; n++)
         send_reading(random_reading());
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_wdata  <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_interval();
      test_interval_clamp();
      test_interval_lowered();
      test_random_blocks();

      // drain the last records before judging
      wait_idle();
      if (mismatch_count == 0 && expected_records.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/sba_pkg.sv
rtl/sba_accum.sv
rtl/sba_serial_div.sv
rtl/sensor_block_averager.sv
verif/sensor_block_averager_tb.sv
